FILE: design/rrt_pkg.sv
package rrt_pkg;

	// Capacity of the table and the widths that follow from it.
	localparam int MAX_REGIONS = 32;
	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	localparam logic FUNC_RESERVE = 1'b0;
	localparam logic FUNC_LOOKUP  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CONFLICT = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

	typedef struct packed {
		logic        func;
		logic [15:0] region_start;
		logic [15:0] region_size;
		logic        is_bit;
		logic [2:0]  bit_position;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] entry_index;
	} rsp_t;

	typedef struct packed {
		logic [15:0] region_start;
		logic [15:0] region_size;
		logic        is_bit;
		logic [2:0]  bit_position;
	} entry_t;

	// Request travelling down the row of cells, with the first hit found so far.
	typedef struct packed {
		req_t             req;
		logic             hit;
		logic [IDX_W-1:0] idx;
	} tok_t;

	// Reports the low five bits of a table index, zero-extended if narrower.
	function automatic logic [4:0] idx_to_out(input logic [IDX_W-1:0] idx);
		logic [IDX_W+4:0] ext;
		ext = {5'd0, idx};
		return ext[4:0];
	endfunction

endpackage

FILE: design/region_reservation_table_top.sv
// Channel   Signals            Direction  Transaction
// request   start, busy, req   in         accepted at a clock edge with start high, busy low
// result    done, rsp          out        shown for one cycle while done is high
//
// Each transaction passes through the launch register, then the row of cells,
// one cell per clock, and then the result register. busy is high from the
// accepting edge until the result appears, so a new request may be given in the
// cycle that shows the previous result. Reset clears the entry count and all
// control state; entry storage is not cleared. The receiver cannot stall.
module region_reservation_table_top import rrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	// Chain links: link 0 is driven by the launch register, link i+1 by cell i.
	logic             chain_vld [0:MAX_REGIONS];
	tok_t             chain_tok [0:MAX_REGIONS];

	logic             busy_q;
	logic             launch_vld_q;
	tok_t             launch_tok_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             finish;
	tok_t             fin_tok;
	logic             wr_en;
	entry_t           wr_entry;
	rsp_t             rsp_nxt;

	assign accept = start && !busy_q;

	assign chain_vld[0] = launch_vld_q;
	assign chain_tok[0] = launch_tok_q;

	// The request enters the row with no hit recorded.
	always_ff @(posedge clk) begin
		if (accept) begin
			launch_tok_q.req <= req;
			launch_tok_q.hit <= 1'b0;
			launch_tok_q.idx <= '0;
		end
	end

	// Each cell holds one table entry. A cell is in use when its index lies below
	// the entry count, so unwritten entries are never consulted.
	for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
		localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(g);
		localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(g);

		rrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (CELL_IDX),
			.occupied (cnt_q > CELL_CNT),
			.wr_en    (wr_en && (cnt_q == CELL_CNT)),
			.wr_entry (wr_entry),
			.vld_in   (chain_vld[g]),
			.tok_in   (chain_tok[g]),
			.vld_out  (chain_vld[g+1]),
			.tok_out  (chain_tok[g+1])
		);
	end

	// When the request leaves the last cell, every stored entry has been checked.
	// A reserve with no clash is appended at the next free entry, if there is one;
	// a clash is reported ahead of a full table.
	assign finish  = chain_vld[MAX_REGIONS];
	assign fin_tok = chain_tok[MAX_REGIONS];

	always_comb begin
		wr_en = 1'b0;
		wr_entry.region_start = fin_tok.req.region_start;
		wr_entry.region_size  = fin_tok.req.region_size;
		wr_entry.is_bit       = fin_tok.req.is_bit;
		wr_entry.bit_position = fin_tok.req.bit_position;
		rsp_nxt.status = STATUS_NOTFOUND;
		rsp_nxt.entry_index = 5'd0;
		if (fin_tok.req.func == FUNC_RESERVE) begin
			if (fin_tok.hit) begin
				rsp_nxt.status = STATUS_CONFLICT;
			end else if (cnt_q >= CNT_W'(MAX_REGIONS)) begin
				rsp_nxt.status = STATUS_FULL;
			end else begin
				rsp_nxt.status = STATUS_OK;
				rsp_nxt.entry_index = idx_to_out(cnt_q[IDX_W-1:0]);
				wr_en = finish;
			end
		end else if (fin_tok.hit) begin
			rsp_nxt.status = STATUS_OK;
			rsp_nxt.entry_index = idx_to_out(fin_tok.idx);
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			launch_vld_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			launch_vld_q <= accept;
			done_q <= finish;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: design/rrt_cell.sv
module rrt_cell import rrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic             occupied,
	input  logic             wr_en,
	input  entry_t           wr_entry,
	input  logic             vld_in,
	input  tok_t             tok_in,
	output logic             vld_out,
	output tok_t             tok_out
);

	entry_t      entry_q;
	logic        vld_q;
	tok_t        tok_q;
	tok_t        tok_nxt;
	logic [16:0] req_end;
	logic [16:0] ent_end;
	logic        spans_meet;
	logic        clash;
	logic        same;

	always_comb begin
		req_end = {1'b0, tok_in.req.region_start} + {1'b0, tok_in.req.region_size};
		ent_end = {1'b0, entry_q.region_start} + {1'b0, entry_q.region_size};
		spans_meet = (tok_in.req.region_size != 16'd0) && (entry_q.region_size != 16'd0) &&
			!(({1'b0, tok_in.req.region_start} >= ent_end) ||
			  (req_end <= {1'b0, entry_q.region_start}));
		if (tok_in.req.is_bit && entry_q.is_bit) begin
			clash = spans_meet && (tok_in.req.bit_position == entry_q.bit_position);
		end else begin
			clash = spans_meet;
		end
		same = (tok_in.req.region_start == entry_q.region_start) &&
			(tok_in.req.region_size == entry_q.region_size) &&
			(tok_in.req.is_bit == entry_q.is_bit) &&
			(!entry_q.is_bit || (tok_in.req.bit_position == entry_q.bit_position));

		tok_nxt = tok_in;
		if (occupied && !tok_in.hit) begin
			if (tok_in.req.func == FUNC_RESERVE) begin
				tok_nxt.hit = clash;
			end else if (same) begin
				tok_nxt.hit = 1'b1;
				tok_nxt.idx = cell_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_entry;
		end
		tok_q <= tok_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	assign vld_out = vld_q;
	assign tok_out = tok_q;

endmodule

FILE: verif/region_reservation_table_checker.sv
`timescale 1ns / 1ps

module region_reservation_table_checker import rrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding,
	output int   requests,
	output int   results,
	output int   ok_seen,
	output int   conflict_seen,
	output int   full_seen,
	output int   miss_seen
);

	entry_t region_copy [MAX_REGIONS];
	int     region_total = 0;
	rsp_t   expected_outcomes [$];
	int     fail_total = 0;
	int     accepted_total = 0;
	int     result_total = 0;
	int     status_tally [4] = '{0, 0, 0, 0};

	// Byte spans are compared in 17 bits so that a span running to the top of
	// the address space does not wrap. Empty spans never meet anything.
	function automatic logic spans_overlap(entry_t a, entry_t b);
		logic [16:0] a_end;
		logic [16:0] b_end;
		a_end = {1'b0, a.region_start} + {1'b0, a.region_size};
		b_end = {1'b0, b.region_start} + {1'b0, b.region_size};
		if (a.region_size == 16'd0 || b.region_size == 16'd0)
			return 1'b0;
		return !(({1'b0, a.region_start} >= b_end) || (a_end <= {1'b0, b.region_start}));
	endfunction

	function automatic logic regions_clash(entry_t a, entry_t b);
		if (!spans_overlap(a, b))
			return 1'b0;
		if (a.is_bit && b.is_bit)
			return a.bit_position == b.bit_position;
		return 1'b1;
	endfunction

	function automatic logic regions_identical(entry_t a, entry_t b);
		if (a.region_start != b.region_start || a.region_size != b.region_size ||
				a.is_bit != b.is_bit)
			return 1'b0;
		return !a.is_bit || (a.bit_position == b.bit_position);
	endfunction

	// Works out the outcome of one request and updates the table copy.
	function automatic rsp_t predict_outcome(req_t r);
		entry_t cand;
		rsp_t   outcome;
		int     i;
		cand = {r.region_start, r.region_size, r.is_bit, r.bit_position};
		outcome.status = STATUS_NOTFOUND;
		outcome.entry_index = 5'd0;
		if (r.func == FUNC_RESERVE) begin
			outcome.status = STATUS_OK;
			for (i = 0; i < region_total; i++) begin
				if (regions_clash(cand, region_copy[i])) begin
					outcome.status = STATUS_CONFLICT;
					break;
				end
			end
			if (outcome.status == STATUS_OK) begin
				if (region_total >= MAX_REGIONS) begin
					outcome.status = STATUS_FULL;
				end else begin
					region_copy[region_total] = cand;
					outcome.entry_index = 5'(region_total);
					region_total++;
				end
			end
		end else begin
			for (i = 0; i < region_total; i++) begin
				if (regions_identical(cand, region_copy[i])) begin
					outcome.status = STATUS_OK;
					outcome.entry_index = 5'(i);
					break;
				end
			end
		end
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			region_total = 0;
			expected_outcomes.delete();
		end else begin
			// A result and a new request can share an edge; the result is
			// matched first since it belongs to the older transaction.
			if (done) begin
				result_total++;
				status_tally[rsp.status]++;
				if (expected_outcomes.size() == 0) begin
					$error("result with no request outstanding: status %0d, entry_index %0d",
						rsp.status, rsp.entry_index);
					fail_total++;
				end else begin
					want = expected_outcomes.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						fail_total++;
					end
					if (rsp.entry_index !== want.entry_index) begin
						$error("entry_index: expected %0d, actual %0d",
							want.entry_index, rsp.entry_index);
						fail_total++;
					end
				end
			end
			if (start && !busy) begin
				expected_outcomes = {expected_outcomes, predict_outcome(req)};
				accepted_total++;
			end
		end
		mismatches    <= fail_total;
		outstanding   <= expected_outcomes.size();
		requests      <= accepted_total;
		results       <= result_total;
		ok_seen       <= status_tally[STATUS_OK];
		conflict_seen <= status_tally[STATUS_CONFLICT];
		full_seen     <= status_tally[STATUS_FULL];
		miss_seen     <= status_tally[STATUS_NOTFOUND];
	end

endmodule

FILE: verif/region_reservation_table_top_tb.sv
`timescale 1ns / 1ps

module region_reservation_table_top_tb;
	import rrt_pkg::*;

	// Length of the random part, and how many of its last transactions are
	// sent back to back with no idling at all.
	localparam int RANDOM_ITEMS = 1200;
	localparam int TAIL_ITEMS   = 150;
	// Quiet time after the last result, sized from the length of a table walk.
	localparam int DRAIN_CYCLES = 2 * (MAX_REGIONS + 2);

	logic clk;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int requests;
	int results;
	int ok_seen;
	int conflict_seen;
	int full_seen;
	int miss_seen;

	// Every reservation that has been sent, whether or not the table took it.
	// Random lookups and overlapping requests are built from these.
	req_t sent_reservations [$];

	region_reservation_table_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	region_reservation_table_checker outcome_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.requests      (requests),
		.results       (results),
		.ok_seen       (ok_seen),
		.conflict_seen (conflict_seen),
		.full_seen     (full_seen),
		.miss_seen     (miss_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety net. The slowest legal run is about 1250 transactions, each a full
	// table walk plus any idling, in all around a millisecond, so this leaves ample headroom.
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic req_t make_req(logic func, logic [15:0] first, logic [15:0] len,
			logic bit_region, logic [2:0] pos);
		req_t r;
		r.func = func;
		r.region_start = first;
		r.region_size = len;
		r.is_bit = bit_region;
		r.bit_position = pos;
		return r;
	endfunction

	// Mostly short regions so that the table fills gradually; now and then an
	// empty span, a larger region or one of any length at all.
	function automatic logic [15:0] region_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			return 16'd0;
		else if (pick < 90)
			return 16'($urandom_range(1, 16));
		else if (pick < 98)
			return 16'($urandom_range(1, 1024));
		return 16'($urandom_range(1, 65535));
	endfunction

	// Builds one random transaction. Most of them are aimed at regions that
	// were reserved earlier: exact and near-miss lookups, overlapping
	// regions, bit regions sharing a byte, and neighbours that just touch.
	// The rest are fresh regions and wholly random noise.
	function automatic req_t random_request();
		req_t r;
		req_t base;
		int   kind;
		base = sent_reservations[$urandom_range(0, sent_reservations.size() - 1)];
		kind = $urandom_range(0, 99);
		r = make_req(FUNC_RESERVE, 16'($urandom), region_length(),
			1'($urandom_range(0, 1)), 3'($urandom));
		if (kind < 30) begin
			r = base;
			r.func = FUNC_LOOKUP;
			// The bit position of a byte region must not matter to a lookup.
			if (!base.is_bit)
				r.bit_position = 3'($urandom);
		end else if (kind < 40) begin
			r = base;
			r.func = FUNC_LOOKUP;
			case ($urandom_range(0, 3))
				0: r.region_size = base.region_size + 16'd1;
				1: r.region_start = base.region_start - 16'd1;
				2: r.is_bit = ~base.is_bit;
				default: r.bit_position = ~base.bit_position;
			endcase
		end else if (kind < 60) begin
			r.region_start = base.region_start + 16'($urandom_range(0,
				(base.region_size == 16'd0) ? 0 : base.region_size - 1));
		end else if (kind < 74) begin
			r.region_start = base.region_start;
			r.region_size = 16'd1;
			r.is_bit = 1'b1;
		end else if (kind < 82) begin
			if ($urandom_range(0, 1))
				r.region_start = base.region_start + base.region_size;
			else
				r.region_start = base.region_start - r.region_size;
		end else if (kind >= 88) begin
			r = make_req(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
				1'($urandom_range(0, 1)), 3'($urandom));
		end
		return r;
	endfunction

	// Presents one transaction and returns just after the edge that accepted
	// it. start is left high so that a following transaction can go straight
	// on without start being lowered and raised in the same time step.
	task automatic issue(input req_t r);
		start <= 1'b1;
		req <= r;
		if (r.func == FUNC_RESERVE)
			sent_reservations = {sent_reservations, r};
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drops start for a short burst. Since busy hides anything shorter than
	// a table walk, the burst is sometimes placed after the result cycle so
	// that the next transaction arrives late by a varying amount.
	task automatic idle_burst(input int cycles, input bit after_result);
		start <= 1'b0;
		if (after_result) begin
			do
				@(posedge clk);
			while (busy);
		end
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		int i;
		bit calm;
		calm = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Lookup on an empty table first.
		issue(make_req(FUNC_LOOKUP,  16'h0000, 16'd1,    1'b0, 3'd0));
		// Both ends of the address space, and neighbours that only touch.
		issue(make_req(FUNC_RESERVE, 16'h0000, 16'd1,    1'b0, 3'd0));
		issue(make_req(FUNC_RESERVE, 16'hFFFF, 16'hFFFF, 1'b0, 3'd7));
		issue(make_req(FUNC_RESERVE, 16'h0001, 16'd16,   1'b0, 3'd0));
		issue(make_req(FUNC_RESERVE, 16'hFFEF, 16'd16,   1'b0, 3'd0));
		// Plain byte overlaps, including one with the region that runs past
		// the top of the address space.
		issue(make_req(FUNC_RESERVE, 16'h0008, 16'd4,    1'b0, 3'd0));
		issue(make_req(FUNC_RESERVE, 16'hFFFE, 16'd2,    1'b0, 3'd0));
		// Bit regions in one byte: distinct positions coexist, a repeated
		// position clashes, and a byte region clashes with any bit.
		issue(make_req(FUNC_RESERVE, 16'h0100, 16'd1,    1'b1, 3'd0));
		issue(make_req(FUNC_RESERVE, 16'h0100, 16'd1,    1'b1, 3'd7));
		issue(make_req(FUNC_RESERVE, 16'h0100, 16'd1,    1'b1, 3'd0));
		issue(make_req(FUNC_RESERVE, 16'h0100, 16'd1,    1'b0, 3'd3));
		issue(make_req(FUNC_RESERVE, 16'h0000, 16'd1,    1'b1, 3'd3));
		// Empty spans sit inside reserved bytes without clashing.
		issue(make_req(FUNC_RESERVE, 16'h0100, 16'd0,    1'b0, 3'd0));
		issue(make_req(FUNC_RESERVE, 16'h0100, 16'd0,    1'b1, 3'd0));
		// Lookups: hits, a byte region found regardless of bit position, and
		// misses on size, flag, position and the all-ones request.
		issue(make_req(FUNC_LOOKUP,  16'h0100, 16'd0,    1'b0, 3'd5));
		issue(make_req(FUNC_LOOKUP,  16'h0100, 16'd1,    1'b1, 3'd7));
		issue(make_req(FUNC_LOOKUP,  16'h0100, 16'd1,    1'b1, 3'd3));
		issue(make_req(FUNC_LOOKUP,  16'h0000, 16'd1,    1'b0, 3'd5));
		issue(make_req(FUNC_LOOKUP,  16'h0000, 16'd2,    1'b0, 3'd0));
		issue(make_req(FUNC_LOOKUP,  16'h0100, 16'd1,    1'b0, 3'd0));
		issue(make_req(FUNC_LOOKUP,  16'hFFFF, 16'hFFFF, 1'b1, 3'd7));

		// Random part. The table fills over the run, after which reservations
		// test the order of the conflict and the full checks. Idling comes
		// and goes in stretches and stops altogether near the end.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0)
				calm = ($urandom_range(0, 2) == 0);
			issue(random_request());
			if (i < RANDOM_ITEMS - TAIL_ITEMS && !calm && $urandom_range(0, 3) == 0)
				idle_burst($urandom_range(1, 4), 1'($urandom_range(0, 1)));
		end
		start <= 1'b0;

		// Let the last transaction complete, then stay a while longer so that
		// any stray result would still be caught.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests giving %0d results: %0d ok or found, %0d conflicts,",
			requests, results, ok_seen, conflict_seen);
		$display("%0d rejected as table full and %0d lookups not found.", full_seen, miss_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
